>>> sv/pbz_pkg.sv
// Shared types, constants and helpers for the piecewise Bezier curve evaluator.
// No dependencies; every other file imports this package.
package pbz_pkg;

  localparam int MAX_NODES    = 16;
  localparam int NEWTON_STEPS = 8;
  localparam int BISECT_STEPS = 17;
  localparam int FRAC_BITS    = 16;

  localparam int QW     = FRAC_BITS + 1;           // Q1.16 value up to and including 1.0
  localparam int IW     = 4;                       // node index width
  localparam int CNT_W  = 5;                       // node_count register width
  localparam int KW     = $clog2(NEWTON_STEPS + 1);
  localparam int JW     = $clog2(BISECT_STEPS + 1);
  localparam int DVD_W  = 2 * FRAC_BITS + 1;       // dividend: 1.0 shifted up by FRAC_BITS
  localparam int DVS_W  = 24;                      // divisor: span width or derivative magnitude
  localparam int ACC_W  = 40;
  localparam int PROD_W = 39;

  typedef logic [QW-1:0] q_t;

  localparam q_t ONE    = QW'(1 << FRAC_BITS);
  localparam q_t HALF_T = QW'(1 << (FRAC_BITS - 1));
  localparam q_t R1     = QW'(((1 << FRAC_BITS) + 1) / 3);
  localparam q_t R2     = QW'((2 * (1 << FRAC_BITS) + 1) / 3);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic REG_NODE_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ST_EVAL      = 2'd0,
    ST_WRITTEN   = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_BAD   = 2'd1,
    KIND_EVAL  = 2'd2
  } kind_t;

  typedef struct packed {
    q_t ax;
    q_t ay;
    q_t ix;
    q_t iy;
    q_t ox;
    q_t oy;
  } node_t;

  typedef struct packed {
    kind_t          kind;
    logic [IW-1:0]  idx;
    node_t          node;
    q_t             qx;
  } item_t;

  function automatic q_t sat1(input logic [QW-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

  // Table contents after reset: the linear two-node curve.
  function automatic node_t reset_node(input logic [IW-1:0] i);
    node_t n;
    n = '0;
    if (i == IW'(0)) begin
      n.ox = R1;
      n.oy = R1;
    end else if (i == IW'(1)) begin
      n.ax = ONE;
      n.ay = ONE;
      n.ix = R2;
      n.iy = R2;
      n.ox = ONE;
      n.oy = ONE;
    end
    return n;
  endfunction

endpackage

>>> sv/pbz_front.sv
// Front end: accepts requests, saturates and classifies them, and queues them
// for the back end in a two-entry queue. Depends on pbz_pkg.
module pbz_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   opcode,
  input  logic [3:0]             node_index,
  input  logic [16:0]            anchor_x,
  input  logic [16:0]            anchor_y,
  input  logic [16:0]            in_handle_x,
  input  logic [16:0]            in_handle_y,
  input  logic [16:0]            out_handle_x,
  input  logic [16:0]            out_handle_y,
  input  logic [16:0]            query_x,
  input  logic [4:0]             n_eff,
  output pbz_pkg::item_t         head,
  output logic                   head_valid,
  input  logic                   pop
);
  import pbz_pkg::*;

  item_t      fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      item;
  logic       push;

  always_comb begin
    item      = '0;
    item.idx  = node_index;
    item.qx   = sat1(query_x);
    item.node.ax = sat1(anchor_x);
    item.node.ay = sat1(anchor_y);
    item.node.ix = sat1(in_handle_x);
    item.node.iy = sat1(in_handle_y);
    item.node.ox = sat1(out_handle_x);
    item.node.oy = sat1(out_handle_y);
    if (opcode == OP_EVAL) begin
      item.kind = KIND_EVAL;
    end else if ({1'b0, node_index} >= n_eff) begin
      item.kind = KIND_BAD;
    end else begin
      item.kind = KIND_WRITE;
    end
  end

  assign in_ready   = (count != 2'd2);
  assign push       = in_valid && in_ready;
  assign head_valid = (count != 2'd0);
  assign head       = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> sv/pbz_div.sv
// Restoring divider, one quotient bit per cycle, for the first guess and the
// Newton correction. Depends on pbz_pkg.
module pbz_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pbz_pkg::DVD_W-1:0] dividend,
  input  logic [pbz_pkg::DVS_W-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic [pbz_pkg::DVD_W-1:0] quotient
);
  import pbz_pkg::*;

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [CW-1:0]    cnt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             take;

  assign trial = {rem, quotient[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign take  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      rem      <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quotient <= {quotient[DVD_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/pbz_back.sv
// Back end: node table, segment search, t solver (guess, Newton, bisection)
// on one shared multiplier and the divider, and the result register.
// Depends on pbz_pkg and pbz_div.
module pbz_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [4:0]             n_eff,
  input  pbz_pkg::item_t         head,
  input  logic                   head_valid,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [16:0]            curve_y,
  output logic [3:0]             segment,
  output logic [16:0]            param_t,
  output logic [1:0]             status
);
  import pbz_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_A0     = 12'b000000000010,
    S_AL     = 12'b000000000100,
    S_SCAN   = 12'b000000001000,
    S_LEFT   = 12'b000000010000,
    S_GDIV   = 12'b000000100000,
    S_NSTART = 12'b000001000000,
    S_BSTART = 12'b000010000000,
    S_BEZ    = 12'b000100000000,
    S_CHECK  = 12'b001000000000,
    S_NDIV   = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_t;

  typedef enum logic [1:0] {
    MODE_NEWT = 2'd0,
    MODE_BIS  = 2'd1,
    MODE_Y    = 2'd2
  } mode_t;

  state_t state;
  mode_t  mode;

  // node table
  node_t                mem [MAX_NODES];
  logic [MAX_NODES-1:0] vld;
  node_t                rd_raw;
  logic                 rd_v;
  logic [IW-1:0]        rd_idx;
  logic [IW-1:0]        raddr;
  node_t                rd_node;
  logic                 tbl_we;
  logic                 scan_hit;

  q_t x;
  q_t p0x, p1x, p2x, p3x, p0y, p1y, p2y, p3y;
  logic [IW-1:0] seg_i;
  logic [IW-1:0] scan_i;
  logic [4:0]    nm1, nm2;

  q_t tcur, bt, lo, hi;
  logic [KW-1:0] k;
  logic [JW-1:0] j;
  logic [3:0]    bstep;
  logic          add_dir;

  q_t uu, tt, ut, w0, w1, w2, w3;
  logic signed [ACC_W-1:0] acc, dacc;

  q_t            res_y, res_t;
  logic [IW-1:0] res_seg;
  status_t       res_st;

  // divider
  logic             div_start, div_busy, div_done;
  logic [DVD_W-1:0] div_dividend, div_quo;
  logic [DVS_W-1:0] div_divisor;

  pbz_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign nm1 = n_eff - 5'd1;
  assign nm2 = n_eff - 5'd2;
  assign pop    = (state == S_IDLE) && head_valid;
  assign tbl_we = pop && (head.kind == KIND_WRITE);
  assign scan_hit = (x <= rd_node.ax) || (scan_i == nm2[IW-1:0]);

  // on a scan hit, fetch the left node of the span next
  always_comb begin
    unique case (state)
      S_A0:    raddr = nm1[IW-1:0];
      S_AL:    raddr = IW'(1);
      S_SCAN:  raddr = scan_hit ? scan_i : (scan_i + IW'(2));
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      mem[head.idx] <= head.node;
    end
    rd_raw <= mem[raddr];
    rd_idx <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rd_v <= 1'b0;
    end else begin
      if (tbl_we) begin
        vld[head.idx] <= 1'b1;
      end
      rd_v <= vld[raddr];
    end
  end

  assign rd_node = rd_v ? rd_raw : reset_node(rd_idx);

  // shared multiplier
  q_t ca, cb, cc, cd, u;
  logic [18:0] w1x3, w2x3, uu3, tt3, ut3;
  logic [19:0] ut6;
  logic signed [20:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_h;
  q_t rqv;
  logic [3:0] last_step;

  assign u    = ONE - bt;
  assign ca   = (mode == MODE_Y) ? p0y : p0x;
  assign cb   = (mode == MODE_Y) ? p1y : p1x;
  assign cc   = (mode == MODE_Y) ? p2y : p2x;
  assign cd   = (mode == MODE_Y) ? p3y : p3x;
  assign w1x3 = {2'b0, w1} + {1'b0, w1, 1'b0};
  assign w2x3 = {2'b0, w2} + {1'b0, w2, 1'b0};
  assign uu3  = {2'b0, uu} + {1'b0, uu, 1'b0};
  assign tt3  = {2'b0, tt} + {1'b0, tt, 1'b0};
  assign ut3  = {2'b0, ut} + {1'b0, ut, 1'b0};
  assign ut6  = {ut3, 1'b0};
  assign last_step = (mode == MODE_NEWT) ? 4'd13 : 4'd10;

  always_comb begin
    case (bstep)
      4'd0:    begin mul_a = $signed({4'b0, u});    mul_b = $signed({1'b0, u});  end
      4'd1:    begin mul_a = $signed({4'b0, bt});   mul_b = $signed({1'b0, bt}); end
      4'd2:    begin mul_a = $signed({4'b0, u});    mul_b = $signed({1'b0, bt}); end
      4'd3:    begin mul_a = $signed({4'b0, uu});   mul_b = $signed({1'b0, u});  end
      4'd4:    begin mul_a = $signed({4'b0, uu});   mul_b = $signed({1'b0, bt}); end
      4'd5:    begin mul_a = $signed({4'b0, u});    mul_b = $signed({1'b0, tt}); end
      4'd6:    begin mul_a = $signed({4'b0, tt});   mul_b = $signed({1'b0, bt}); end
      4'd7:    begin mul_a = $signed({4'b0, w0});   mul_b = $signed({1'b0, ca}); end
      4'd8:    begin mul_a = $signed({2'b0, w1x3}); mul_b = $signed({1'b0, cb}); end
      4'd9:    begin mul_a = $signed({2'b0, w2x3}); mul_b = $signed({1'b0, cc}); end
      4'd10:   begin mul_a = $signed({4'b0, w3});   mul_b = $signed({1'b0, cd}); end
      4'd11: begin
        mul_a = $signed({2'b0, uu3});
        mul_b = $signed({1'b0, cb}) - $signed({1'b0, ca});
      end
      4'd12: begin
        mul_a = $signed({1'b0, ut6});
        mul_b = $signed({1'b0, cc}) - $signed({1'b0, cb});
      end
      4'd13: begin
        mul_a = $signed({2'b0, tt3});
        mul_b = $signed({1'b0, cd}) - $signed({1'b0, cc});
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod_h = prod + PROD_W'(HALF_T);
  assign rqv    = prod_h[FRAC_BITS +: QW];

  // curve value, derivative and error
  logic [ACC_W-1:0] acc_h;
  logic [23:0]      r_full;
  q_t               r;
  logic             d_neg, d_zero;
  logic [ACC_W-1:0] d_abs;
  logic [DVS_W-1:0] ad;
  logic             e_neg, e_zero;
  q_t               ae;

  assign acc_h  = acc + ACC_W'(HALF_T);
  assign r_full = acc_h[FRAC_BITS +: 24];
  assign r      = (r_full > 24'(ONE)) ? ONE : r_full[QW-1:0];
  assign d_neg  = dacc[ACC_W-1];
  assign d_abs  = d_neg ? -dacc : dacc;
  assign ad     = d_abs[FRAC_BITS +: DVS_W];
  assign d_zero = (ad == '0);
  assign e_neg  = (r < x);
  assign e_zero = (r == x);
  assign ae     = e_neg ? (x - r) : (r - x);

  // bisection step
  q_t          lo_n, hi_n;
  logic [JW-1:0] j_n;
  logic [QW:0] lh_sum, lh_up;
  q_t          lh_gap;
  logic        bis_done;

  always_comb begin
    if (r < x) begin
      lo_n = bt;
      hi_n = hi;
    end else begin
      lo_n = lo;
      hi_n = bt;
    end
    j_n      = j + JW'(1);
    lh_sum   = {1'b0, lo_n} + {1'b0, hi_n};
    lh_up    = lh_sum + (QW+1)'(1);
    lh_gap   = hi_n - lo_n;
    bis_done = (lh_gap <= QW'(1)) || (j_n == JW'(BISECT_STEPS));
  end

  // Newton update
  logic [DVD_W:0] t_sum;
  assign t_sum = {{(DVD_W+1-QW){1'b0}}, tcur} + {1'b0, div_quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            x       <= head.qx;
            res_y   <= '0;
            res_t   <= '0;
            res_seg <= '0;
            unique case (head.kind)
              KIND_WRITE: begin res_st <= ST_WRITTEN;   state <= S_OUT; end
              KIND_BAD:   begin res_st <= ST_BAD_INDEX; state <= S_OUT; end
              KIND_EVAL:  begin res_st <= ST_EVAL;      state <= S_A0;  end
              default:    begin res_st <= ST_BAD_INDEX; state <= S_OUT; end
            endcase
          end
        end
        S_A0: begin
          if (x <= rd_node.ax) begin
            res_y <= rd_node.ay;
            state <= S_OUT;
          end else begin
            state <= S_AL;
          end
        end
        S_AL: begin
          if (x >= rd_node.ax) begin
            res_y   <= rd_node.ay;
            res_seg <= nm2[IW-1:0];
            res_t   <= ONE;
            state   <= S_OUT;
          end else begin
            scan_i <= '0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          // hold the right node of the first span whose end reaches x
          if (scan_hit) begin
            seg_i <= scan_i;
            p3x   <= rd_node.ax;
            p3y   <= rd_node.ay;
            p2x   <= rd_node.ix;
            p2y   <= rd_node.iy;
            state <= S_LEFT;
          end else begin
            scan_i <= scan_i + IW'(1);
          end
        end
        S_LEFT: begin
          p0x <= rd_node.ax;
          p0y <= rd_node.ay;
          p1x <= rd_node.ox;
          p1y <= rd_node.oy;
          k   <= '0;
          if (p3x > rd_node.ax) begin
            if (x <= rd_node.ax) begin
              tcur  <= '0;
              state <= S_NSTART;
            end else begin
              div_dividend <= {x - rd_node.ax, FRAC_BITS'(0)};
              div_divisor  <= DVS_W'(p3x - rd_node.ax);
              div_start    <= 1'b1;
              state        <= S_GDIV;
            end
          end else begin
            tcur  <= HALF_T;
            state <= S_NSTART;
          end
        end
        S_GDIV: begin
          if (div_done) begin
            tcur  <= (div_quo > DVD_W'(ONE)) ? ONE : div_quo[QW-1:0];
            state <= S_NSTART;
          end
        end
        S_NSTART: begin
          if (k == KW'(NEWTON_STEPS)) begin
            state <= S_BSTART;
          end else begin
            bt    <= tcur;
            mode  <= MODE_NEWT;
            bstep <= '0;
            state <= S_BEZ;
          end
        end
        S_BSTART: begin
          lo    <= '0;
          hi    <= ONE;
          j     <= '0;
          bt    <= HALF_T;
          mode  <= MODE_BIS;
          bstep <= '0;
          state <= S_BEZ;
        end
        S_BEZ: begin
          case (bstep)
            4'd0:  uu <= rqv;
            4'd1:  tt <= rqv;
            4'd2:  ut <= rqv;
            4'd3:  w0 <= rqv;
            4'd4:  w1 <= rqv;
            4'd5:  w2 <= rqv;
            4'd6:  w3 <= rqv;
            4'd7:  acc <= {prod[PROD_W-1], prod};
            4'd8, 4'd9, 4'd10: acc <= acc + {prod[PROD_W-1], prod};
            4'd11: dacc <= {prod[PROD_W-1], prod};
            default: dacc <= dacc + {prod[PROD_W-1], prod};
          endcase
          if (bstep == last_step) begin
            state <= S_CHECK;
          end else begin
            bstep <= bstep + 4'd1;
          end
        end
        S_CHECK: begin
          unique case (mode)
            MODE_NEWT: begin
              if (e_zero) begin
                bt    <= tcur;
                mode  <= MODE_Y;
                bstep <= '0;
                state <= S_BEZ;
              end else if (d_zero) begin
                state <= S_BSTART;
              end else begin
                add_dir      <= (e_neg != d_neg);
                div_dividend <= {ae, FRAC_BITS'(0)};
                div_divisor  <= ad;
                div_start    <= 1'b1;
                state        <= S_NDIV;
              end
            end
            MODE_BIS: begin
              lo <= lo_n;
              hi <= hi_n;
              j  <= j_n;
              bstep <= '0;
              state <= S_BEZ;
              if (bis_done) begin
                tcur <= lh_up[QW:1];
                bt   <= lh_up[QW:1];
                mode <= MODE_Y;
              end else begin
                bt <= lh_sum[QW:1];
              end
            end
            default: begin
              res_y   <= r;
              res_t   <= tcur;
              res_seg <= seg_i;
              state   <= S_OUT;
            end
          endcase
        end
        S_NDIV: begin
          if (div_done) begin
            if (add_dir) begin
              tcur <= (t_sum > (DVD_W+1)'(ONE)) ? ONE : t_sum[QW-1:0];
            end else begin
              tcur <= (div_quo > DVD_W'(tcur)) ? '0 : (tcur - div_quo[QW-1:0]);
            end
            k     <= k + KW'(1);
            state <= S_NSTART;
          end
        end
        S_OUT: begin
          // drop into the result register once it is free
          if (!out_valid || out_ready) begin
            curve_y   <= res_y;
            segment   <= res_seg;
            param_t   <= res_t;
            status    <= res_st;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_table_write_idle: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> (state == S_IDLE))
    else $error("table written outside idle");

  a_div_quiet_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_busy)
    else $error("divider busy while idle");

  a_y_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((curve_y <= ONE) && (param_t <= ONE)))
    else $error("result out of range");

  a_seg_in_table: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_EVAL)) |-> ({1'b0, segment} <= nm2))
    else $error("segment beyond table");

endmodule

>>> sv/piecewise_bezier_curve_eval.sv
// Top level of the piecewise cubic Bezier tone curve: config register,
// front end with request queue, back end solver. Depends on pbz_pkg,
// pbz_front and pbz_back.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one request per handshake:
//   opcode 0 loads node node_index of the table, opcode 1 evaluates y at
//   query_x. Output channel (out_valid/out_ready) returns one result per
//   request in order: curve_y, segment, param_t, status.
//   node_count sits at APB address 0; write it only while the block is idle.
//   A node write goes straight to the result register; a query at an end
//   of the curve returns that end node's y. An interior query runs the
//   segment scan, a first-guess division where the span has width, then
//   per Newton step the Bezier terms on the shared multiplier and a
//   divider pass, then bisection steps when Newton does not hit x exactly,
//   and a last multiplier pass for y.
//   One request is solved at a time; the two-entry queue keeps taking
//   requests while the solver works and while a result waits.
//   Reset sets node_count to 2 and the table to the linear curve, at once.
//   A stalled receiver holds the result register; the solver then waits.
module piecewise_bezier_curve_eval (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [3:0]  node_index,
  input  logic [16:0] anchor_x,
  input  logic [16:0] anchor_y,
  input  logic [16:0] in_handle_x,
  input  logic [16:0] in_handle_y,
  input  logic [16:0] out_handle_x,
  input  logic [16:0] out_handle_y,
  input  logic [16:0] query_x,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] curve_y,
  output logic [3:0]  segment,
  output logic [16:0] param_t,
  output logic [1:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pbz_pkg::*;

  logic [CNT_W-1:0] node_count;
  logic [4:0]       n_eff;
  item_t            head;
  logic             head_valid;
  logic             pop;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_NODE_COUNT);
  assign prdata  = reg_sel ? {{(32-CNT_W){1'b0}}, node_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CNT_W'(2);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      node_count <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    if (node_count < CNT_W'(2)) begin
      n_eff = 5'd2;
    end else if (node_count > CNT_W'(MAX_NODES)) begin
      n_eff = 5'(MAX_NODES);
    end else begin
      n_eff = node_count;
    end
  end

  pbz_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .node_index   (node_index),
    .anchor_x     (anchor_x),
    .anchor_y     (anchor_y),
    .in_handle_x  (in_handle_x),
    .in_handle_y  (in_handle_y),
    .out_handle_x (out_handle_x),
    .out_handle_y (out_handle_y),
    .query_x      (query_x),
    .n_eff        (n_eff),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop)
  );

  pbz_back u_back (
    .clk        (clk),
    .rst        (rst),
    .n_eff      (n_eff),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .curve_y    (curve_y),
    .segment    (segment),
    .param_t    (param_t),
    .status     (status)
  );

endmodule
